// File: rtl/core/tlr_pkg.sv
// Shared types, constants and tables for the thin-lens ray generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package tlr_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int CORDIC_MAX     = 24;
  localparam int CORDIC_DEFAULT = 16;
  localparam int RSQRT_ITERS    = 5;

  localparam int CFG_W = 24;

  typedef enum logic [1:0] {
    CFG_TAN_HALF_FOV   = 2'd0,
    CFG_ASPECT_RATIO   = 2'd1,
    CFG_LENS_APERTURE  = 2'd2,
    CFG_FOCUS_DISTANCE = 2'd3
  } cfg_idx_e;

  localparam logic [18:0] TAN_RST    = 19'd37837;
  localparam logic [19:0] ASPECT_RST = 20'd65536;
  localparam logic [16:0] APER_RST   = 17'd0;
  localparam logic [23:0] FOCUS_RST  = 24'd1024;

  // CORDIC start gain 0.6072529350 at FRAC_BITS fraction bits, rounded
  localparam int CORDIC_X0 =
    (652032874 + (1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

  localparam logic signed [18:0] ONE_Q16     = 19'sd65536;
  localparam logic signed [18:0] NEG_ONE_Q16 = -19'sd65536;

  // reciprocal square root seeds, Q.16
  localparam logic [17:0] SEED_A = 18'd53248;
  localparam logic [17:0] SEED_B = 18'd36864;
  localparam logic [17:0] SEED_C = 18'd26624;
  localparam logic [17:0] SEED_D = 18'd20480;

  typedef logic signed [19:0] cxy_t;
  typedef logic signed [31:0] cz_t;
  typedef logic signed [39:0] vec_t;
  typedef logic signed [18:0] vn_t;

  // arctangent table in binary angle units (2^32 per turn)
  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] r;
    case (idx)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/tlr_cordic_cell.sv
// One CORDIC rotation cell of the lens sin/cos chain.
// Depends on tlr_pkg; side data rides along unchanged.
`default_nettype none

module tlr_cordic_cell import tlr_pkg::*; #(
  parameter int Idx   = 0,
  parameter int SideW = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire cxy_t             x_i,
  input  wire cxy_t             y_i,
  input  wire cz_t              z_i,
  input  wire logic [SideW-1:0] side_i,
  output logic                  valid_o,
  output cxy_t                  x_o,
  output cxy_t                  y_o,
  output cz_t                   z_o,
  output logic [SideW-1:0]      side_o
);

  localparam logic [31:0] Atan = atan_turn(Idx);

  cxy_t x_d, y_d, xs, ys;
  cz_t  z_d, at;
  logic valid_q;
  cxy_t x_q, y_q;
  cz_t  z_q;
  logic [SideW-1:0] side_q;

  always_comb begin
    xs = x_i >>> Idx;
    ys = y_i >>> Idx;
    at = $signed({1'b0, Atan[30:0]});
    if (!z_i[31]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - at;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

// File: rtl/core/tlr_rsqrt_cell.sv
// One Newton step of the reciprocal square root, three register stages.
// Depends on tlr_pkg; side data rides along unchanged.
`default_nettype none

module tlr_rsqrt_cell import tlr_pkg::*; #(
  parameter int SideW = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [35:0]      s_i,
  input  wire logic [17:0]      y_i,
  input  wire logic [SideW-1:0] side_i,
  output logic                  valid_o,
  output logic [35:0]           s_o,
  output logic [17:0]           y_o,
  output logic [SideW-1:0]      side_o
);

  logic [2:0]       valid_q;
  logic [35:0]      s1_q, s2_q, s3_q;
  logic [17:0]      y1_q, y2_q, y3_q;
  logic [19:0]      yy_q;
  logic [17:0]      tm_q;
  logic [SideW-1:0] sd1_q, sd2_q, sd3_q;

  logic [35:0]        yy_full;
  logic [39:0]        p_full;
  logic signed [24:0] tm_s;
  logic [35:0]        yn_full;

  always_comb begin
    yy_full = y_i * y_i;
    p_full  = s1_q[35:16] * yy_q;
    tm_s    = 25'sd196608 - $signed({1'b0, p_full[39:16]});
    yn_full = y2_q * tm_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s_i;
    y1_q  <= y_i;
    yy_q  <= yy_full[35:16];
    sd1_q <= side_i;
    s2_q  <= s1_q;
    y2_q  <= y1_q;
    tm_q  <= tm_s[24] ? 18'd0 : tm_s[17:0];
    sd2_q <= sd1_q;
    s3_q  <= s2_q;
    y3_q  <= yn_full[34:17];
    sd3_q <= sd2_q;
  end

  assign valid_o = valid_q[2];
  assign s_o     = s3_q;
  assign y_o     = y3_q;
  assign side_o  = sd3_q;

endmodule

`default_nettype wire

// File: rtl/core/thin_lens_ray_generator.sv
// Thin-lens camera ray generator top level: screen mapping, lens CORDIC chain,
// normalization and Newton reciprocal square root cells. Uses tlr_pkg and cells.
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------------------------------
//  sample   | start, busy       | low_x_i .. lens_radius_i
//  ray      | valid_o (strobe)  | origin_x_o, origin_y_o, dir_x_o, dir_y_o, dir_z_o
//  config   | cfg_we_i          | cfg_idx_i, cfg_data_i
//
// One transaction per cycle; busy is never raised.
// The pipeline depth is set by one CORDIC cell per rotation and three
// stages per Newton step.
// Reset clears the valid chain and loads the register defaults.
// The receiver cannot stall; results are strobed for one cycle.
`default_nettype none

module thin_lens_ray_generator import tlr_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [16:0]       low_x_i,
  input  wire logic [16:0]       low_y_i,
  input  wire logic [16:0]       high_x_i,
  input  wire logic [16:0]       high_y_i,
  input  wire logic [15:0]       jitter_u_i,
  input  wire logic [15:0]       jitter_v_i,
  input  wire logic [15:0]       lens_angle_i,
  input  wire logic [15:0]       lens_radius_i,
  output logic                   valid_o,
  output logic signed [17:0]     origin_x_o,
  output logic signed [17:0]     origin_y_o,
  output logic signed [17:0]     dir_x_o,
  output logic signed [17:0]     dir_y_o,
  output logic signed [16:0]     dir_z_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i
);

  localparam int NCell = (CORDIC_STAGES < CORDIC_MAX) ? CORDIC_STAGES : CORDIC_MAX;
  localparam int CSideW = 40 + 40 + 16 + 2;
  localparam int RSideW = 3 * 19 + 1 + 36;

  // ---------------- configuration
  logic [18:0] tan_q;
  logic [19:0] aspect_q;
  logic [16:0] aper_q;
  logic [23:0] focus_q;
  logic [22:0] t_q;
  logic [38:0] t_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tan_q    <= TAN_RST;
      aspect_q <= ASPECT_RST;
      aper_q   <= APER_RST;
      focus_q  <= FOCUS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TAN_HALF_FOV:   tan_q    <= cfg_data_i[18:0];
        CFG_ASPECT_RATIO:   aspect_q <= cfg_data_i[19:0];
        CFG_LENS_APERTURE:  aper_q   <= cfg_data_i[16:0];
        CFG_FOCUS_DISTANCE: focus_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign t_full = tan_q * aspect_q;
  always_ff @(posedge clk_i) begin
    t_q <= t_full[38:16];
  end

  assign busy = 1'b0;

  // ---------------- stage A: input register
  logic        a_v_q;
  logic [16:0] a_lx_q, a_ly_q, a_hx_q, a_hy_q;
  logic [15:0] a_ju_q, a_jv_q, a_ang_q, a_rr_q;

  // ---------------- stage B: jitter, CORDIC start
  logic               b_v_q;
  logic signed [19:0] b_px_q, b_py_q;
  logic [15:0]        b_rr_q;
  logic [1:0]         b_qf_q;
  cz_t                b_z_q;

  logic signed [17:0] dxs, dys;
  logic signed [34:0] jx_full, jy_full;
  logic [31:0]        ang32;
  logic [32:0]        ang_sum;
  logic [2:0]         qf;
  logic signed [33:0] z_full;

  always_comb begin
    dxs     = $signed({1'b0, a_hx_q}) - $signed({1'b0, a_lx_q});
    dys     = $signed({1'b0, a_hy_q}) - $signed({1'b0, a_ly_q});
    jx_full = dxs * $signed({1'b0, a_ju_q});
    jy_full = dys * $signed({1'b0, a_jv_q});
    ang32   = {a_ang_q, 16'd0};
    ang_sum = {1'b0, ang32} + 33'h020000000;
    qf      = ang_sum[32:30];
    z_full  = $signed({2'b00, ang32}) - $signed({1'b0, qf, 30'd0});
  end

  // ---------------- stage C: screen coordinates
  logic               c_v_q;
  logic signed [17:0] c_sx_q, c_sy_q;
  logic [15:0]        c_rr_q;
  logic [1:0]         c_qf_q;
  cz_t                c_z_q;
  logic signed [20:0] sx_raw, sy_raw;

  function automatic logic signed [17:0] sat_q16(input logic signed [20:0] v);
    logic signed [17:0] r;
    if (v > 21'sd65536)       r = 18'sd65536;
    else if (v < -21'sd65536) r = -18'sd65536;
    else                      r = v[17:0];
    return r;
  endfunction

  always_comb begin
    sx_raw = ($signed({b_px_q[19], b_px_q}) <<< 1) - 21'sd65536;
    sy_raw = 21'sd65536 - ($signed({b_py_q[19], b_py_q}) <<< 1);
  end

  // ---------------- stage D: first focal products
  logic               d_v_q;
  logic signed [23:0] d_fx1_q;
  logic signed [19:0] d_fy1_q;
  logic [15:0]        d_rr_q;
  logic [1:0]         d_qf_q;
  cz_t                d_z_q;
  logic signed [41:0] fx1_full;
  logic signed [37:0] fy1_full;

  assign fx1_full = $signed({1'b0, t_q}) * c_sx_q;
  assign fy1_full = $signed({1'b0, tan_q}) * c_sy_q;

  // ---------------- stage E: focal plane point
  logic               e_v_q;
  vec_t               e_fx_q, e_fy_q;
  logic [15:0]        e_rr_q;
  logic [1:0]         e_qf_q;
  cz_t                e_z_q;
  logic signed [48:0] fx_full;
  logic signed [44:0] fy_full;

  assign fx_full = d_fx1_q * $signed({1'b0, focus_q});
  assign fy_full = d_fy1_q * $signed({1'b0, focus_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else begin
      a_v_q <= start && !busy;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_lx_q  <= low_x_i;
    a_ly_q  <= low_y_i;
    a_hx_q  <= high_x_i;
    a_hy_q  <= high_y_i;
    a_ju_q  <= jitter_u_i;
    a_jv_q  <= jitter_v_i;
    a_ang_q <= lens_angle_i;
    a_rr_q  <= lens_radius_i;

    // jitter offset is negative for a reversed rectangle
    b_px_q  <= $signed({3'b000, a_lx_q}) + $signed({jx_full[34], jx_full[34:16]});
    b_py_q  <= $signed({3'b000, a_ly_q}) + $signed({jy_full[34], jy_full[34:16]});
    b_rr_q  <= a_rr_q;
    b_qf_q  <= qf[1:0];
    b_z_q   <= z_full[31:0];

    c_sx_q  <= sat_q16(sx_raw);
    c_sy_q  <= sat_q16(sy_raw);
    c_rr_q  <= b_rr_q;
    c_qf_q  <= b_qf_q;
    c_z_q   <= b_z_q;

    d_fx1_q <= fx1_full[39:16];
    d_fy1_q <= fy1_full[35:16];
    d_rr_q  <= c_rr_q;
    d_qf_q  <= c_qf_q;
    d_z_q   <= c_z_q;

    e_fx_q  <= {fx_full[48], fx_full[48:10]};
    e_fy_q  <= {{5{fy_full[44]}}, fy_full[44:10]};
    e_rr_q  <= d_rr_q;
    e_qf_q  <= d_qf_q;
    e_z_q   <= d_z_q;
  end

  // ---------------- CORDIC chain
  logic              cv   [NCell+1];
  cxy_t              cx   [NCell+1];
  cxy_t              cy   [NCell+1];
  cz_t               cz   [NCell+1];
  logic [CSideW-1:0] cside[NCell+1];

  assign cv[0]    = e_v_q;
  assign cx[0]    = cxy_t'(CORDIC_X0);
  assign cy[0]    = '0;
  assign cz[0]    = e_z_q;
  assign cside[0] = {e_fx_q, e_fy_q, e_rr_q, e_qf_q};

  for (genvar g = 0; g < NCell; g++) begin : g_cordic
    tlr_cordic_cell #(.Idx(g), .SideW(CSideW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[g]),
      .x_i     (cx[g]),
      .y_i     (cy[g]),
      .z_i     (cz[g]),
      .side_i  (cside[g]),
      .valid_o (cv[g+1]),
      .x_o     (cx[g+1]),
      .y_o     (cy[g+1]),
      .z_o     (cz[g+1]),
      .side_o  (cside[g+1])
    );
  end

  vec_t        k_fx, k_fy;
  logic [15:0] k_rr;
  logic [1:0]  k_qf;
  assign {k_fx, k_fy, k_rr, k_qf} = cside[NCell];

  // ---------------- T1: quadrant fold
  logic               t1_v_q;
  logic signed [17:0] t1_sn_q, t1_cs_q;
  vec_t               t1_fx_q, t1_fy_q;
  logic [15:0]        t1_rr_q;
  logic signed [20:0] xw, yw, c_raw, s_raw;

  always_comb begin
    xw = {cx[NCell][19], cx[NCell]};
    yw = {cy[NCell][19], cy[NCell]};
    case (k_qf)
      2'd0: begin c_raw = xw;  s_raw = yw;  end
      2'd1: begin c_raw = -yw; s_raw = xw;  end
      2'd2: begin c_raw = -xw; s_raw = -yw; end
      2'd3: begin c_raw = yw;  s_raw = -xw; end
      default: begin c_raw = xw; s_raw = yw; end
    endcase
  end

  // ---------------- T2 / T3: lens point
  logic               t2_v_q, t3_v_q;
  logic signed [18:0] t2_ox1_q, t2_oy1_q;
  vec_t               t2_fx_q, t2_fy_q, t3_fx_q, t3_fy_q;
  logic signed [17:0] t3_ox_q, t3_oy_q;
  logic signed [34:0] ox1_full, oy1_full;
  logic signed [36:0] ox_full, oy_full;

  assign ox1_full = t1_sn_q * $signed({1'b0, t1_rr_q});
  assign oy1_full = t1_cs_q * $signed({1'b0, t1_rr_q});
  assign ox_full  = t2_ox1_q * $signed({1'b0, aper_q});
  assign oy_full  = t2_oy1_q * $signed({1'b0, aper_q});

  // ---------------- T4: direction vector
  logic               t4_v_q;
  vec_t               t4_vx_q, t4_vy_q, t4_vz_q;
  logic signed [17:0] t4_ox_q, t4_oy_q;

  // ---------------- N1..N4: normalize, sum of squares, seed
  logic               n1_v_q, n2_v_q, n3_v_q, n4_v_q;
  vec_t               n1_vx_q, n1_vy_q, n1_vz_q, n2_vx_q, n2_vy_q, n2_vz_q;
  logic [39:0]        n1_m_q;
  logic signed [17:0] n1_ox_q, n1_oy_q, n2_ox_q, n2_oy_q, n3_ox_q, n3_oy_q;
  logic signed [17:0] n4_ox_q, n4_oy_q;
  logic [5:0]         n2_lead_q;
  logic               n2_zero_q, n3_zero_q, n4_zero_q;
  vn_t                n3_vx_q, n3_vy_q, n3_vz_q, n4_vx_q, n4_vy_q, n4_vz_q;
  logic [35:0]        n4_s_q;
  logic [17:0]        n4_y_q;

  logic [39:0] ax, ay, az, mx;
  logic [5:0]  lead;
  vec_t        shx, shy, shz;
  logic [37:0] sq_sum;
  logic [35:0] sqx, sqy, sqz;
  logic [17:0] seed;

  always_comb begin
    ax = t4_vx_q[39] ? 40'(-t4_vx_q) : 40'(t4_vx_q);
    ay = t4_vy_q[39] ? 40'(-t4_vy_q) : 40'(t4_vy_q);
    az = t4_vz_q[39] ? 40'(-t4_vz_q) : 40'(t4_vz_q);
    mx = ax;
    if (ay > mx) mx = ay;
    if (az > mx) mx = az;

    lead = '0;
    for (int b = 0; b < 40; b++) begin
      if (n1_m_q[b]) lead = 6'(b);
    end

    if (n2_lead_q >= 6'd16) begin
      shx = n2_vx_q >>> (n2_lead_q - 6'd16);
      shy = n2_vy_q >>> (n2_lead_q - 6'd16);
      shz = n2_vz_q >>> (n2_lead_q - 6'd16);
    end else begin
      shx = n2_vx_q <<< (6'd16 - n2_lead_q);
      shy = n2_vy_q <<< (6'd16 - n2_lead_q);
      shz = n2_vz_q <<< (6'd16 - n2_lead_q);
    end

    sqx    = 36'(n3_vx_q * n3_vx_q);
    sqy    = 36'(n3_vy_q * n3_vy_q);
    sqz    = 36'(n3_vz_q * n3_vz_q);
    sq_sum = {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};
    if (sq_sum[37:32] < 6'd2)      seed = SEED_A;
    else if (sq_sum[37:32] < 6'd4) seed = SEED_B;
    else if (sq_sum[37:32] < 6'd8) seed = SEED_C;
    else                           seed = SEED_D;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v_q <= 1'b0;
      t2_v_q <= 1'b0;
      t3_v_q <= 1'b0;
      t4_v_q <= 1'b0;
      n1_v_q <= 1'b0;
      n2_v_q <= 1'b0;
      n3_v_q <= 1'b0;
      n4_v_q <= 1'b0;
    end else begin
      t1_v_q <= cv[NCell];
      t2_v_q <= t1_v_q;
      t3_v_q <= t2_v_q;
      t4_v_q <= t3_v_q;
      n1_v_q <= t4_v_q;
      n2_v_q <= n1_v_q;
      n3_v_q <= n2_v_q;
      n4_v_q <= n3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_sn_q  <= sat_q16(s_raw);
    t1_cs_q  <= sat_q16(c_raw);
    t1_fx_q  <= k_fx;
    t1_fy_q  <= k_fy;
    t1_rr_q  <= k_rr;

    t2_ox1_q <= ox1_full[34:16];
    t2_oy1_q <= oy1_full[34:16];
    t2_fx_q  <= t1_fx_q;
    t2_fy_q  <= t1_fy_q;

    t3_ox_q  <= sat_q16(ox_full[36:16]);
    t3_oy_q  <= sat_q16(oy_full[36:16]);
    t3_fx_q  <= t2_fx_q;
    t3_fy_q  <= t2_fy_q;

    t4_vx_q  <= t3_fx_q - 40'(t3_ox_q);
    t4_vy_q  <= t3_fy_q - 40'(t3_oy_q);
    t4_vz_q  <= -$signed({10'd0, focus_q, 6'd0});
    t4_ox_q  <= t3_ox_q;
    t4_oy_q  <= t3_oy_q;

    n1_vx_q  <= t4_vx_q;
    n1_vy_q  <= t4_vy_q;
    n1_vz_q  <= t4_vz_q;
    n1_m_q   <= mx;
    n1_ox_q  <= t4_ox_q;
    n1_oy_q  <= t4_oy_q;

    n2_vx_q   <= n1_vx_q;
    n2_vy_q   <= n1_vy_q;
    n2_vz_q   <= n1_vz_q;
    n2_lead_q <= lead;
    n2_zero_q <= (n1_m_q == '0);
    n2_ox_q   <= n1_ox_q;
    n2_oy_q   <= n1_oy_q;

    n3_vx_q   <= shx[18:0];
    n3_vy_q   <= shy[18:0];
    n3_vz_q   <= shz[18:0];
    n3_zero_q <= n2_zero_q;
    n3_ox_q   <= n2_ox_q;
    n3_oy_q   <= n2_oy_q;

    n4_s_q    <= sq_sum[35:0];
    n4_y_q    <= seed;
    n4_vx_q   <= n3_vx_q;
    n4_vy_q   <= n3_vy_q;
    n4_vz_q   <= n3_vz_q;
    n4_zero_q <= n3_zero_q;
    n4_ox_q   <= n3_ox_q;
    n4_oy_q   <= n3_oy_q;
  end

  // ---------------- Newton chain
  logic              rv   [RSQRT_ITERS+1];
  logic [35:0]       rs   [RSQRT_ITERS+1];
  logic [17:0]       ry   [RSQRT_ITERS+1];
  logic [RSideW-1:0] rside[RSQRT_ITERS+1];

  assign rv[0]    = n4_v_q;
  assign rs[0]    = n4_s_q;
  assign ry[0]    = n4_y_q;
  assign rside[0] = {n4_vx_q, n4_vy_q, n4_vz_q, n4_zero_q, n4_ox_q, n4_oy_q};

  for (genvar g = 0; g < RSQRT_ITERS; g++) begin : g_rsqrt
    tlr_rsqrt_cell #(.SideW(RSideW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (rv[g]),
      .s_i     (rs[g]),
      .y_i     (ry[g]),
      .side_i  (rside[g]),
      .valid_o (rv[g+1]),
      .s_o     (rs[g+1]),
      .y_o     (ry[g+1]),
      .side_o  (rside[g+1])
    );
  end

  vn_t                r_vx, r_vy, r_vz;
  logic               r_zero;
  logic signed [17:0] r_ox, r_oy;
  assign {r_vx, r_vy, r_vz, r_zero, r_ox, r_oy} = rside[RSQRT_ITERS];

  // ---------------- F1 / F2: scale and saturate
  logic               f1_v_q, f2_v_q;
  logic signed [21:0] f1_dx_q, f1_dy_q, f1_dz_q;
  logic               f1_zero_q;
  logic signed [17:0] f1_ox_q, f1_oy_q;
  logic signed [37:0] px_full, py_full, pz_full;
  logic signed [17:0] f2_ox_q, f2_oy_q, f2_dx_q, f2_dy_q;
  logic signed [16:0] f2_dz_q;
  logic signed [17:0] dz_sat;

  assign px_full = r_vx * $signed({1'b0, ry[RSQRT_ITERS]});
  assign py_full = r_vy * $signed({1'b0, ry[RSQRT_ITERS]});
  assign pz_full = r_vz * $signed({1'b0, ry[RSQRT_ITERS]});

  function automatic logic signed [17:0] sat22(input logic signed [21:0] v);
    logic signed [17:0] r;
    if (v > 22'sd65536)       r = 18'sd65536;
    else if (v < -22'sd65536) r = -18'sd65536;
    else                      r = v[17:0];
    return r;
  endfunction

  always_comb begin
    dz_sat = sat22(f1_dz_q);
    if (dz_sat > 18'sd0) dz_sat = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else begin
      f1_v_q <= rv[RSQRT_ITERS];
      f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_dx_q   <= px_full[37:16];
    f1_dy_q   <= py_full[37:16];
    f1_dz_q   <= pz_full[37:16];
    f1_zero_q <= r_zero;
    f1_ox_q   <= r_ox;
    f1_oy_q   <= r_oy;

    f2_ox_q <= f1_ox_q;
    f2_oy_q <= f1_oy_q;
    if (f1_zero_q) begin
      f2_dx_q <= '0;
      f2_dy_q <= '0;
      f2_dz_q <= -17'sd65536;
    end else begin
      f2_dx_q <= sat22(f1_dx_q);
      f2_dy_q <= sat22(f1_dy_q);
      f2_dz_q <= dz_sat[16:0];
    end
  end

  assign valid_o    = f2_v_q;
  assign origin_x_o = f2_ox_q;
  assign origin_y_o = f2_oy_q;
  assign dir_x_o    = f2_dx_q;
  assign dir_y_o    = f2_dy_q;
  assign dir_z_o    = f2_dz_q;

`ifndef SYNTHESIS
  a_dz_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (dir_z_o[16] || dir_z_o == '0))
    else $error("dir_z positive");

  a_origin_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (origin_x_o >= -18'sd65536 && origin_x_o <= 18'sd65536 &&
                 origin_y_o >= -18'sd65536 && origin_y_o <= 18'sd65536))
    else $error("origin out of range");

  a_pinhole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && aper_q == '0 && $stable(aper_q)) |->
      (origin_x_o == '0 && origin_y_o == '0))
    else $error("pinhole origin not zero");
`endif

endmodule

`default_nettype wire

// File: tb/ray_checker.sv
// Checker for the thin-lens ray generator: predicts each ray from the sample and
// the shadowed register values, then compares strobed rays in order. Uses tlr_pkg.
`timescale 1ns / 100ps

module ray_checker import tlr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [16:0]        low_x_i,
  input  wire logic [16:0]        low_y_i,
  input  wire logic [16:0]        high_x_i,
  input  wire logic [16:0]        high_y_i,
  input  wire logic [15:0]        jitter_u_i,
  input  wire logic [15:0]        jitter_v_i,
  input  wire logic [15:0]        lens_angle_i,
  input  wire logic [15:0]        lens_radius_i,
  input  wire logic               valid_o,
  input  wire logic signed [17:0] origin_x_o,
  input  wire logic signed [17:0] origin_y_o,
  input  wire logic signed [17:0] dir_x_o,
  input  wire logic signed [17:0] dir_y_o,
  input  wire logic signed [16:0] dir_z_o,
  input  wire logic               cfg_we_i,
  input  wire cfg_idx_e           cfg_idx_i,
  input  wire logic [CFG_W-1:0]   cfg_data_i,
  output int                      fail_cnt,
  output int                      pending
);

  localparam longint UNIT  = 65536;
  localparam int     STAGES = 16;

  typedef struct {
    logic signed [17:0] ox, oy, dx, dy;
    logic signed [16:0] dz;
  } ray_t;

  ray_t exp_rays[$];

  logic [18:0] tan_q;
  logic [19:0] aspect_q;
  logic [16:0] aper_q;
  logic [23:0] focus_q;

  longint arc_tab[24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic ray_t trace_ray();
    ray_t r;
    longint px, py, sx, sy, t, fx, fy, fd, ap, rr;
    longint a, qf, z, x, y, nx, sn, cs, ox, oy;
    longint v[3], m, s2, hi, g, g2, p, tm, d[3];
    px = longint'(low_x_i) + (((longint'(high_x_i) - longint'(low_x_i))
         * longint'(jitter_u_i)) >>> 16);
    py = longint'(low_y_i) + (((longint'(high_y_i) - longint'(low_y_i))
         * longint'(jitter_v_i)) >>> 16);
    sx = clip(2 * px - UNIT, -UNIT, UNIT);
    sy = clip(UNIT - 2 * py, -UNIT, UNIT);
    fd = longint'(focus_q);
    ap = longint'(aper_q);
    rr = longint'(lens_radius_i);
    t  = (longint'(tan_q) * longint'(aspect_q)) >>> 16;
    fx = (((t * sx) >>> 16) * fd) >>> 10;
    fy = (((longint'(tan_q) * sy) >>> 16) * fd) >>> 10;
    // CORDIC on a 32-bit binary angle, folded to the nearest quarter turn
    a  = longint'(lens_angle_i) << 16;
    qf = (a + (64'sd1 << 29)) >> 30;
    z  = a - (qf << 30);
    x  = (64'sd652032874 + (64'sd1 << 13)) >>> 14;
    y  = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - arc_tab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + arc_tab[i];
      end
      x = nx;
    end
    case (qf & 3)
      0: begin cs = x;  sn = y;  end
      1: begin cs = -y; sn = x;  end
      2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
    sn = clip(sn, -UNIT, UNIT);
    cs = clip(cs, -UNIT, UNIT);
    ox = clip((((sn * rr) >>> 16) * ap) >>> 16, -UNIT, UNIT);
    oy = clip((((cs * rr) >>> 16) * ap) >>> 16, -UNIT, UNIT);
    v[0] = fx - ox;
    v[1] = fy - oy;
    v[2] = -fd * 64;
    m = 0;
    for (int k = 0; k < 3; k++) begin
      if ((v[k] < 0 ? -v[k] : v[k]) > m) m = v[k] < 0 ? -v[k] : v[k];
    end
    if (m == 0) begin
      d[0] = 0; d[1] = 0; d[2] = -UNIT;
    end else begin
      while (m >= (64'sd1 << 17)) begin
        for (int k = 0; k < 3; k++) v[k] = v[k] >>> 1;
        m = m >> 1;
      end
      while (m < (64'sd1 << 16)) begin
        for (int k = 0; k < 3; k++) v[k] = v[k] * 2;
        m = m * 2;
      end
      s2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      hi = s2 >>> 32;
      if (hi < 2)      g = 53248;
      else if (hi < 4) g = 36864;
      else if (hi < 8) g = 26624;
      else             g = 20480;
      // Newton steps for 1/sqrt(S)
      for (int k = 0; k < 5; k++) begin
        g2 = (g * g) >>> 16;
        p  = ((s2 >>> 16) * g2) >>> 16;
        tm = 3 * UNIT - p;
        if (tm < 0) tm = 0;
        g = (g * tm) >>> 17;
      end
      for (int k = 0; k < 3; k++) d[k] = (v[k] * g) >>> 16;
    end
    r.ox = 18'(ox);
    r.oy = 18'(oy);
    r.dx = 18'(clip(d[0], -UNIT, UNIT));
    r.dy = 18'(clip(d[1], -UNIT, UNIT));
    r.dz = 17'(clip(d[2], -UNIT, 0));
    return r;
  endfunction

  task automatic report_err(string what, longint got, longint want);
    $display("%0t ray mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_cnt++;
  endtask

  initial fail_cnt = 0;
  assign pending = exp_rays.size();

  always @(posedge clk_i or negedge rst_ni) begin
    ray_t e;
    if (!rst_ni) begin
      tan_q    <= TAN_RST;
      aspect_q <= ASPECT_RST;
      aper_q   <= APER_RST;
      focus_q  <= FOCUS_RST;
    end else begin
      if (start && !busy) exp_rays.push_back(trace_ray());
      if (valid_o) begin
        if (exp_rays.size() == 0) begin
          $display("%0t ray transaction with no sample outstanding", $time);
          fail_cnt++;
        end else begin
          e = exp_rays.pop_front();
          if (origin_x_o !== e.ox) report_err("origin_x", origin_x_o, e.ox);
          if (origin_y_o !== e.oy) report_err("origin_y", origin_y_o, e.oy);
          if (dir_x_o !== e.dx) report_err("dir_x", dir_x_o, e.dx);
          if (dir_y_o !== e.dy) report_err("dir_y", dir_y_o, e.dy);
          if (dir_z_o !== e.dz) report_err("dir_z", dir_z_o, e.dz);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TAN_HALF_FOV:   tan_q    <= cfg_data_i[18:0];
          CFG_ASPECT_RATIO:   aspect_q <= cfg_data_i[19:0];
          CFG_LENS_APERTURE:  aper_q   <= cfg_data_i[16:0];
          CFG_FOCUS_DISTANCE: focus_q  <= cfg_data_i[23:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for the thin-lens ray generator: clock, reset, register phases
// and sample stimulus. Depends on tlr_pkg, ray_checker and the block itself.
`timescale 1ns / 100ps

module tb_top import tlr_pkg::*; ();

  localparam int STALL_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [16:0] low_x_i = '0, low_y_i = '0, high_x_i = '0, high_y_i = '0;
  logic [15:0] jitter_u_i = '0, jitter_v_i = '0, lens_angle_i = '0, lens_radius_i = '0;
  logic valid_o;
  logic signed [17:0] origin_x_o, origin_y_o, dir_x_o, dir_y_o;
  logic signed [16:0] dir_z_o;
  logic cfg_we_i = 1'b0;
  cfg_idx_e cfg_idx_i = CFG_TAN_HALF_FOV;
  logic [CFG_W-1:0] cfg_data_i = '0;
  int fail_cnt, pending, quiet_cycles;

  always #2 clk_i = ~clk_i;

  thin_lens_ray_generator uut (.*);
  ray_checker chk (.*);

  // watchdog: cycles with no transaction on either side
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_sample(logic [16:0] lx, ly, hx, hy, logic [15:0] ju, jv, ang, rad);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    low_x_i       <= lx;
    low_y_i       <= ly;
    high_x_i      <= hx;
    high_y_i      <= hy;
    jitter_u_i    <= ju;
    jitter_v_i    <= jv;
    lens_angle_i  <= ang;
    lens_radius_i <= rad;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [16:0] edge_val();
    return $urandom_range(0, 9) == 0 ? 17'($urandom_range(0, 131071))
                                     : 17'($urandom_range(0, 65536));
  endfunction

  task automatic send_random();
    send_sample(edge_val(), edge_val(), edge_val(), edge_val(), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [23:0] tan, asp, ap, fd);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_TAN_HALF_FOV;   cfg_data_i <= tan; @(posedge clk_i);
    cfg_idx_i <= CFG_ASPECT_RATIO;   cfg_data_i <= asp; @(posedge clk_i);
    cfg_idx_i <= CFG_LENS_APERTURE;  cfg_data_i <= ap;  @(posedge clk_i);
    cfg_idx_i <= CFG_FOCUS_DISTANCE; cfg_data_i <= fd;  @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset settings: corners, flat and reversed rectangles, out-of-range edges
    send_sample(0, 0, 0, 0, 0, 0, 0, 0);
    send_sample(65536, 65536, 65536, 65536, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(0, 0, 65536, 65536, 16'hFFFF, 0, 16'h4000, 16'h8000);
    send_sample(65536, 65536, 0, 0, 16'h8000, 16'hFFFF, 16'h8000, 16'hFFFF);
    send_sample(131071, 131071, 131071, 131071, 0, 0, 16'hC000, 0);
    send_sample(17'h15555, 17'h0AAAA, 17'h0AAAA, 17'h15555, 16'h5555, 16'hAAAA,
                16'h2000, 16'h5555);
    drain();
    // pinhole off, aperture above one: lens points saturate
    write_regs(24'd37837, 24'd65536, 24'h1FFFF, 24'd1024);
    send_sample(0, 0, 65536, 65536, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF);
    send_sample(0, 0, 65536, 65536, 16'h8000, 16'h8000, 16'h4000, 16'hFFFF);
    send_sample(0, 0, 65536, 65536, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
    send_sample(0, 0, 65536, 65536, 16'h8000, 16'h8000, 16'hC000, 16'hFFFF);
    send_sample(0, 0, 65536, 65536, 16'h8000, 16'h8000, 16'hE000, 16'hFFFF);
    drain();
    // zero focus distance: direction collapses unless the lens point is off axis
    write_regs(24'd37837, 24'd65536, 24'd0, 24'd0);
    send_sample(32768, 32768, 32768, 32768, 0, 0, 0, 0);
    send_sample(0, 0, 65536, 65536, 16'h1234, 16'h8765, 16'h1111, 16'hFFFF);
    drain();
    write_regs(24'd37837, 24'd65536, 24'd65536, 24'd0);
    send_sample(32768, 32768, 32768, 32768, 0, 0, 16'h3000, 16'hFFFF);
    send_sample(32768, 32768, 32768, 32768, 0, 0, 16'h0000, 16'h0000);
    drain();
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: write_regs(24'd393216, 24'd1048575, 24'd65536, 24'd10240000);
        1: write_regs(24'd570, 24'd1, 24'd0, 24'd102);
        2: write_regs(24'h7FFFF, 24'hFFFFF, 24'h1FFFF, 24'hFFFFFF);
        3: write_regs(24'd570, 24'd1048575, 24'd65536, 24'd10240000);
        default: write_regs(24'($urandom_range(570, 393216)),
                            24'($urandom_range(1, 1048575)),
                            24'($urandom_range(0, 65536)),
                            $urandom_range(0, 1) ? 24'($urandom_range(102, 10240))
                                                 : 24'($urandom_range(102, 10240000)));
      endcase
      repeat (44) send_random();
      drain();
    end
    if (fail_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
